// ----- rtl/core/swe_pkg.sv -----
`default_nettype none
package swe_pkg;

   localparam int unsigned VISIBLE_LINES = 192;

   localparam logic [2:0] MODE_TICK  = 3'd0;
   localparam logic [2:0] MODE_SWAP  = 3'd1;
   localparam logic [2:0] MODE_SET   = 3'd2;
   localparam logic [2:0] MODE_RESET = 3'd3;
   localparam logic [2:0] MODE_ALLOC = 3'd4;

   localparam logic [1:0] KIND_XFER  = 2'd0;
   localparam logic [1:0] KIND_ACK   = 2'd1;
   localparam logic [1:0] KIND_GRANT = 2'd2;

   localparam logic [3:0] NO_CHANNEL = 4'd15;

   localparam logic CSR_NULL_SINK   = 1'b0;
   localparam logic CSR_DEFAULT_SRC = 1'b1;

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  current_line;
      logic [3:0]  channel_index;
      logic [31:0] dest_address;
      logic [31:0] table_address;
      logic        word_width;
      logic        defer_activation;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] read_address;
      logic [31:0] write_address;
      logic        wide;
      logic [3:0]  granted_channel;
      logic        granted;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_SWAP,
      OP_SET,
      OP_RESET,
      OP_ALLOC
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  next_line;
      logic        ch_ok;
      logic [3:0]  ch;
      logic [31:0] dest;
      logic [31:0] tbl;
      logic        wide;
      logic        defer;
   } cmd_type;

   typedef struct packed {
      logic full;
   } qin_ctl_type;

   typedef struct packed {
      logic not_empty;
   } qout_ctl_type;

endpackage
`default_nettype wire

// ----- rtl/core/scanline_register_write_engine.sv -----
// requests wait in the queue until the back end is idle; an edit or swap answer is
// registered when the back end takes it; a line tick streams CHANNELS transfers on
// consecutive cycles. The back end serves one request at a time: a line tick until its
// last transfer, an allocation until a grant or a miss (one channel tested per cycle)
// busy rises only when the two-entry request queue is full; results are never stalled
// synchronous reset: queue empty, all channels free at address 0 with 32-bit entries
`default_nettype none
module scanline_register_write_engine #(
   parameter int unsigned CHANNELS = 10
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   input  swe_pkg::req_type req_data,
   output logic             rsp_valid,
   output swe_pkg::rsp_type rsp_data,
   input  wire              csr_we,
   input  wire              csr_index,
   input  wire  [31:0]      csr_wdata
);
   import swe_pkg::*;

   logic [31:0]  null_sink_addr_ff;
   logic [31:0]  default_src_ff;
   logic         accept;
   logic         push;
   cmd_type      front_cmd;
   cmd_type      q_head;
   qin_ctl_type  qin_ctl;
   qout_ctl_type qout_ctl;
   logic         q_pop;

   assign accept = start && !busy;
   assign busy   = qin_ctl.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         null_sink_addr_ff <= '0;
         default_src_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NULL_SINK:   null_sink_addr_ff <= csr_wdata;
            CSR_DEFAULT_SRC: default_src_ff    <= csr_wdata;
         endcase
      end
   end

   swe_front #(
      .CHANNELS(CHANNELS)
   ) u_front (
      .accept(accept),
      .req   (req_data),
      .push  (push),
      .cmd   (front_cmd)
   );

   swe_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_cmd (front_cmd),
      .push   (push),
      .pop    (q_pop),
      .in_ctl (qin_ctl),
      .out_ctl(qout_ctl),
      .head   (q_head)
   );

   swe_back #(
      .CHANNELS(CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .null_sink  (null_sink_addr_ff),
      .default_src(default_src_ff),
      .q_valid    (qout_ctl.not_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

// ----- rtl/core/swe_front.sv -----
`default_nettype none
module swe_front #(
   parameter int unsigned CHANNELS = 10
) (
   input  wire              accept,
   input  swe_pkg::req_type req,
   output logic             push,
   output swe_pkg::cmd_type cmd
);
   import swe_pkg::*;

   logic [8:0] line_sum;

   always_comb begin
      line_sum          = {1'b0, req.current_line} + 9'd1;
      cmd.next_line     = (line_sum >= 9'(VISIBLE_LINES)) ? 8'd0 : line_sum[7:0];
      cmd.ch_ok         = (req.channel_index < 4'(CHANNELS));
      cmd.ch            = req.channel_index;
      cmd.dest          = req.dest_address;
      cmd.tbl           = req.table_address;
      cmd.wide          = req.word_width;
      cmd.defer         = req.defer_activation;
      cmd.op            = OP_TICK;
      push              = accept;
      unique case (req.mode)
         MODE_TICK:  cmd.op = OP_TICK;
         MODE_SWAP:  cmd.op = OP_SWAP;
         MODE_SET:   cmd.op = OP_SET;
         MODE_RESET: cmd.op = OP_RESET;
         MODE_ALLOC: cmd.op = OP_ALLOC;
         default:    push   = 1'b0;
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/core/swe_queue.sv -----
`default_nettype none
module swe_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  swe_pkg::cmd_type      wr_cmd,
   input  wire                   push,
   input  wire                   pop,
   output swe_pkg::qin_ctl_type  in_ctl,
   output swe_pkg::qout_ctl_type out_ctl,
   output swe_pkg::cmd_type      head
);
   import swe_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
      head      = entry_ff[rd_ptr_ff];
      in_ctl.full       = (count_ff == 2'd2);
      out_ctl.not_empty = (count_ff != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/swe_back.sv -----
`default_nettype none
module swe_back #(
   parameter int unsigned CHANNELS = 10
) (
   input  wire              clock,
   input  wire              reset,
   input  wire  [31:0]      null_sink,
   input  wire  [31:0]      default_src,
   input  wire              q_valid,
   input  swe_pkg::cmd_type q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   output swe_pkg::rsp_type rsp_data
);
   import swe_pkg::*;

   localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_SCAN
   } state_type;

   state_type        state_ff;
   logic [CH_W-1:0]  cnt_ff;
   cmd_type          cmd_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   logic [31:0]      active_table_ff  [CHANNELS];
   logic [31:0]      pending_table_ff [CHANNELS];
   logic [31:0]      active_target_ff [CHANNELS];
   logic [31:0]      pending_target_ff[CHANNELS];
   logic [CHANNELS-1:0] entry_wide_ff;

   logic [31:0]      line_offset;
   logic [31:0]      read_addr;
   logic             chan_free;
   logic [CH_W-1:0]  head_ch;

   function automatic rsp_type make_rsp(logic [1:0] kind, logic [31:0] rd, logic [31:0] wr,
                                        logic wide, logic [3:0] gch, logic gr, logic last);
      rsp_type r;
      r.kind            = kind;
      r.read_address    = rd;
      r.write_address   = wr;
      r.wide            = wide;
      r.granted_channel = gch;
      r.granted         = gr;
      r.last            = last;
      return r;
   endfunction

   always_comb begin
      q_pop       = (state_ff == ST_IDLE) && q_valid;
      head_ch     = q_head.ch[CH_W-1:0];
      line_offset = entry_wide_ff[cnt_ff] ? {22'd0, cmd_ff.next_line, 2'b00}
                                          : {23'd0, cmd_ff.next_line, 1'b0};
      read_addr   = active_table_ff[cnt_ff] + line_offset;
      chan_free   = (active_target_ff[cnt_ff] == null_sink) &&
                    (pending_target_ff[cnt_ff] == null_sink);
      rsp_valid   = rsp_valid_ff;
      rsp_data    = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         entry_wide_ff <= '1;
         for (int i = 0; i < CHANNELS; i++) begin
            active_table_ff[i]   <= '0;
            pending_table_ff[i]  <= '0;
            active_target_ff[i]  <= '0;
            pending_target_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  cmd_ff <= q_head;
                  cnt_ff <= '0;
                  unique case (q_head.op)
                     OP_TICK: begin
                        state_ff <= ST_TICK;
                     end
                     OP_ALLOC: begin
                        state_ff <= ST_SCAN;
                     end
                     OP_SWAP: begin
                        for (int i = 0; i < CHANNELS; i++) begin
                           active_table_ff[i]  <= pending_table_ff[i];
                           active_target_ff[i] <= pending_target_ff[i];
                        end
                        rsp_valid_ff <= 1'b1;
                        rsp_data_ff  <= make_rsp(KIND_ACK, '0, '0, 1'b0, 4'd0, 1'b0, 1'b1);
                     end
                     OP_SET: begin
                        if (q_head.ch_ok) begin
                           pending_target_ff[head_ch] <= q_head.dest;
                           pending_table_ff[head_ch]  <= q_head.tbl;
                           entry_wide_ff[head_ch]     <= q_head.wide;
                           if (!q_head.defer) begin
                              active_target_ff[head_ch] <= q_head.dest;
                              active_table_ff[head_ch]  <= q_head.tbl;
                           end
                        end
                        rsp_valid_ff <= 1'b1;
                        rsp_data_ff  <= make_rsp(KIND_ACK, '0, '0, 1'b0, 4'd0, 1'b0, 1'b1);
                     end
                     OP_RESET: begin
                        if (q_head.ch_ok) begin
                           pending_target_ff[head_ch] <= null_sink;
                           pending_table_ff[head_ch]  <= default_src;
                           entry_wide_ff[head_ch]     <= 1'b1;
                           if (!q_head.defer) begin
                              active_target_ff[head_ch] <= null_sink;
                              active_table_ff[head_ch]  <= default_src;
                           end
                        end
                        rsp_valid_ff <= 1'b1;
                        rsp_data_ff  <= make_rsp(KIND_ACK, '0, '0, 1'b0, 4'd0, 1'b0, 1'b1);
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_TICK: begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= make_rsp(KIND_XFER, read_addr, active_target_ff[cnt_ff],
                                        entry_wide_ff[cnt_ff], 4'd0, 1'b0, cnt_ff == LAST_CH);
               if (cnt_ff == LAST_CH) begin
                  state_ff <= ST_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_SCAN: begin
               if (chan_free) begin
                  pending_target_ff[cnt_ff] <= cmd_ff.dest;
                  pending_table_ff[cnt_ff]  <= cmd_ff.tbl;
                  entry_wide_ff[cnt_ff]     <= cmd_ff.wide;
                  if (!cmd_ff.defer) begin
                     active_target_ff[cnt_ff] <= cmd_ff.dest;
                     active_table_ff[cnt_ff]  <= cmd_ff.tbl;
                  end
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= make_rsp(KIND_GRANT, '0, '0, 1'b0, 4'(cnt_ff), 1'b1, 1'b1);
                  state_ff     <= ST_IDLE;
               end else if (cnt_ff == LAST_CH) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= make_rsp(KIND_GRANT, '0, '0, 1'b0, NO_CHANNEL, 1'b0, 1'b1);
                  state_ff     <= ST_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/swe_checker.sv -----
`default_nettype none
module swe_checker (
   input wire              clock,
   input wire              reset,
   input wire              start,
   input wire              busy,
   input wire              rsp_valid,
   input swe_pkg::rsp_type rsp_data
);
   import swe_pkg::*;

   // transfers of one line tick come on back-to-back cycles
   a_tick_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_XFER && !rsp_data.last |=> rsp_valid)
      else $error("line tick burst broken");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("activity right after reset");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_XFER |-> rsp_data.last)
      else $error("single answer without last");

   a_grant_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_GRANT && !rsp_data.granted
      |-> rsp_data.granted_channel == NO_CHANNEL)
      else $error("failed allocation channel code");

   // the queue only fills after a request was offered
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy without a request");

endmodule

bind scanline_register_write_engine swe_checker u_swe_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .rsp_valid(rsp_valid),
   .rsp_data (rsp_data)
);
`default_nettype wire

// ----- sim/tb_top.sv -----
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import swe_pkg::*;

   localparam int CHANNELS = 10;
   localparam int RESET_CYCLES = 11;
   localparam int SETTLE_CYCLES = CHANNELS + 8;
   localparam int CYCLE_LIMIT = 300000;
   localparam int ITEMS_PER_PHASE = 96;
   localparam int PHASES = 4;
   localparam int MAX_PRINTED = 200;
   localparam logic [31:0] DEST_SCROLL = 32'h0400_0006;

   class write_engine_model;
      bit [31:0] null_sink;
      bit [31:0] default_src;
      bit [31:0] active_tbl[CHANNELS];
      bit [31:0] pending_tbl[CHANNELS];
      bit [31:0] active_target[CHANNELS];
      bit [31:0] pending_target[CHANNELS];
      bit        entry_wide[CHANNELS];
      rsp_type   expected_results[$];
      int unsigned failures;
      int unsigned printed;

      function new();
         null_sink = '0;
         default_src = '0;
         failures = 0;
         printed = 0;
         for (int i = 0; i < CHANNELS; i++) begin
            active_tbl[i] = '0;
            pending_tbl[i] = '0;
            active_target[i] = '0;
            pending_target[i] = '0;
            entry_wide[i] = 1'b1;
         end
      endfunction

      function void set_register(logic idx, bit [31:0] value);
         if (idx == CSR_NULL_SINK) begin
            null_sink = value;
         end else begin
            default_src = value;
         end
      endfunction

      function int outstanding();
         return expected_results.size();
      endfunction

      function void report(string msg);
         failures++;
         if (printed < MAX_PRINTED) begin
            printed++;
            $display("mismatch at %0t: %s", $realtime, msg);
         end
      endfunction

      function void load_channel(int ch, bit [31:0] target, bit [31:0] tbl, bit wide,
                                 bit defer);
         pending_target[ch] = target;
         pending_tbl[ch] = tbl;
         entry_wide[ch] = wide;
         if (!defer) begin
            active_target[ch] = target;
            active_tbl[ch] = tbl;
         end
      endfunction

      function void take_request(req_type r);
         rsp_type   res;
         bit [31:0] next_line;
         bit        found;
         res = '0;
         res.kind = KIND_ACK;
         res.last = 1'b1;
         found = 1'b0;
         case (r.mode)
            MODE_TICK: begin
               next_line = 32'(r.current_line) + 32'd1;
               if (next_line >= VISIBLE_LINES) begin
                  next_line = '0;
               end
               for (int i = 0; i < CHANNELS; i++) begin
                  res = '0;
                  res.kind = KIND_XFER;
                  res.read_address = active_tbl[i] + next_line * (entry_wide[i] ? 32'd4 : 32'd2);
                  res.write_address = active_target[i];
                  res.wide = entry_wide[i];
                  res.last = (i == CHANNELS - 1);
                  expected_results.push_back(res);
               end
            end
            MODE_SWAP: begin
               for (int i = 0; i < CHANNELS; i++) begin
                  active_target[i] = pending_target[i];
                  active_tbl[i] = pending_tbl[i];
               end
               expected_results.push_back(res);
            end
            MODE_SET: begin
               if (r.channel_index < CHANNELS) begin
                  load_channel(r.channel_index, r.dest_address, r.table_address,
                               r.word_width, r.defer_activation);
               end
               expected_results.push_back(res);
            end
            MODE_RESET: begin
               if (r.channel_index < CHANNELS) begin
                  load_channel(r.channel_index, null_sink, default_src, 1'b1,
                               r.defer_activation);
               end
               expected_results.push_back(res);
            end
            MODE_ALLOC: begin
               res.kind = KIND_GRANT;
               res.granted_channel = NO_CHANNEL;
               for (int i = 0; i < CHANNELS; i++) begin
                  if (!found && active_target[i] == null_sink &&
                      pending_target[i] == null_sink) begin
                     found = 1'b1;
                     load_channel(i, r.dest_address, r.table_address, r.word_width,
                                  r.defer_activation);
                     res.granted_channel = 4'(i);
                     res.granted = 1'b1;
                  end
               end
               expected_results.push_back(res);
            end
            default: begin
            end
         endcase
      endfunction

      function void match_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            report($sformatf("result with nothing expected: kind %0d rd %h wr %h",
                             got.kind, got.read_address, got.write_address));
            return;
         end
         want = expected_results.pop_front();
         if (got.kind !== want.kind || got.read_address !== want.read_address ||
             got.write_address !== want.write_address || got.wide !== want.wide ||
             got.granted_channel !== want.granted_channel ||
             got.granted !== want.granted || got.last !== want.last) begin
            report($sformatf({"got kind %0d rd %h wr %h wide %b ch %0d gr %b last %b, ",
                              "want kind %0d rd %h wr %h wide %b ch %0d gr %b last %b"},
                             got.kind, got.read_address, got.write_address, got.wide,
                             got.granted_channel, got.granted, got.last,
                             want.kind, want.read_address, want.write_address, want.wide,
                             want.granted_channel, want.granted, want.last));
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic    csr_index = CSR_NULL_SINK;
   logic [31:0] csr_wdata = '0;

   write_engine_model book = new();
   int unsigned cycles = 0;

   scanline_register_write_engine #(
      .CHANNELS(CHANNELS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         book.match_result(rsp_data);
      end
   end

   function automatic req_type make_req(logic [2:0] mode, logic [7:0] line, logic [3:0] ch,
                                        logic [31:0] dest, logic [31:0] tbl, logic wide,
                                        logic defer);
      req_type r;
      r.mode = mode;
      r.current_line = line;
      r.channel_index = ch;
      r.dest_address = dest;
      r.table_address = tbl;
      r.word_width = wide;
      r.defer_activation = defer;
      return r;
   endfunction

   function automatic logic [31:0] pick_address();
      case ($urandom_range(0, 9))
         0: return book.null_sink;
         1: return 32'h0000_0000;
         2: return 32'hFFFF_FFFF;
         3: return DEST_SCROLL;
         4: return book.default_src;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      r = '0;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         r.mode = MODE_TICK;
      end else if (pick < 40) begin
         r.mode = MODE_SWAP;
      end else if (pick < 60) begin
         r.mode = MODE_SET;
      end else if (pick < 75) begin
         r.mode = MODE_RESET;
      end else if (pick < 95) begin
         r.mode = MODE_ALLOC;
      end else begin
         r.mode = MODE_ALLOC + 3'($urandom_range(1, 3));
      end
      case ($urandom_range(0, 9))
         0: r.current_line = 8'(VISIBLE_LINES - 2);
         1: r.current_line = 8'(VISIBLE_LINES - 1);
         2: r.current_line = 8'hFF;
         default: r.current_line = 8'($urandom);
      endcase
      if ($urandom_range(0, 99) < 85) begin
         r.channel_index = 4'($urandom_range(0, CHANNELS - 1));
      end else begin
         r.channel_index = 4'($urandom_range(CHANNELS, 15));
      end
      r.dest_address = pick_address();
      r.table_address = pick_address();
      r.word_width = 1'($urandom);
      r.defer_activation = ($urandom_range(0, 99) < 30);
      return r;
   endfunction

   function automatic int unsigned gap_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic pause(input int unsigned n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_request(input req_type r);
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      book.take_request(r);
   endtask

   task automatic send_with_gap(input req_type r, input bit no_idle);
      int unsigned g;
      send_request(r);
      g = no_idle ? 0 : gap_length();
      if (g != 0) pause(g);
   endtask

   task automatic wait_drained();
      pause(1);
      while (book.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_registers(input logic [31:0] null_sink, input logic [31:0] src);
      csr_we <= 1'b1;
      csr_index <= CSR_NULL_SINK;
      csr_wdata <= null_sink;
      @(posedge clock);
      book.set_register(CSR_NULL_SINK, null_sink);
      csr_index <= CSR_DEFAULT_SRC;
      csr_wdata <= src;
      @(posedge clock);
      book.set_register(CSR_DEFAULT_SRC, src);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_directed();
      send_with_gap(make_req(MODE_TICK, 8'd0, 4'd0, '0, '0, 1'b0, 1'b0), 1'b0);
      send_with_gap(make_req(MODE_TICK, 8'(VISIBLE_LINES - 2), 4'd0, '0, '0, 1'b0, 1'b0),
                    1'b0);
      send_with_gap(make_req(MODE_TICK, 8'(VISIBLE_LINES - 1), 4'd0, '0, '0, 1'b0, 1'b0),
                    1'b0);
      send_with_gap(make_req(MODE_TICK, 8'hFF, 4'd0, '0, '0, 1'b0, 1'b0), 1'b0);
      send_with_gap(make_req(MODE_ALLOC, 8'd0, 4'd0, DEST_SCROLL, 32'h0200_0000, 1'b0,
                             1'b0), 1'b0);
      send_with_gap(make_req(MODE_SET, 8'd0, 4'(CHANNELS - 1), 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 1'b1, 1'b1), 1'b0);
      send_with_gap(make_req(MODE_TICK, 8'd100, 4'd0, '0, '0, 1'b0, 1'b0), 1'b0);
      send_with_gap(make_req(MODE_SWAP, 8'd0, 4'd0, '0, '0, 1'b0, 1'b0), 1'b0);
      send_with_gap(make_req(MODE_SET, 8'd0, 4'(CHANNELS), 32'h1234_5678, 32'h9ABC_DEF0,
                             1'b0, 1'b0), 1'b0);
      send_with_gap(make_req(MODE_RESET, 8'd0, 4'd15, '0, '0, 1'b0, 1'b0), 1'b0);
      send_with_gap(make_req(MODE_RESET, 8'd0, 4'd0, '0, '0, 1'b0, 1'b1), 1'b0);
      // fill every free channel, the last one finds none
      for (int i = 0; i < CHANNELS - 1; i++) begin
         send_with_gap(make_req(MODE_ALLOC, 8'd0, 4'd0, DEST_SCROLL + 32'(i),
                                32'h0300_0000 + 32'(i) * 32'h100, 1'(i), 1'(i >> 1)), 1'b1);
      end
      send_with_gap(make_req(MODE_ALLOC + 3'd1, 8'd0, 4'd0, '0, '0, 1'b0, 1'b0), 1'b0);
      send_with_gap(make_req(3'd7, 8'hFF, 4'hF, '1, '1, 1'b1, 1'b1), 1'b0);
      send_with_gap(make_req(MODE_TICK, 8'hFE, 4'd0, '0, '0, 1'b0, 1'b0), 1'b0);
      send_with_gap(make_req(MODE_SWAP, 8'd0, 4'd0, '0, '0, 1'b0, 1'b0), 1'b0);
      send_with_gap(make_req(MODE_ALLOC, 8'd0, 4'd0, 32'h0400_0010, 32'h0700_0000, 1'b1,
                             1'b0), 1'b0);
   endtask

   task automatic run_random(input int unsigned count);
      req_type     r;
      int unsigned done;
      int unsigned k;
      done = 0;
      k = 0;
      while (done < count) begin
         r = random_request();
         send_with_gap(r, (k % 50) < 12);
         if (r.mode <= MODE_ALLOC) done++;
         k++;
      end
   endtask

   initial begin
      logic [31:0] sink_setting[PHASES];
      logic [31:0] src_setting[PHASES];
      sink_setting[0] = 32'h0000_0000;
      src_setting[0] = 32'h0000_0000;
      sink_setting[1] = 32'hFFFF_FFFF;
      src_setting[1] = 32'hFFFF_FFFF;
      sink_setting[2] = DEST_SCROLL;
      src_setting[2] = $urandom;
      sink_setting[3] = $urandom;
      src_setting[3] = 32'h0000_0000;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < PHASES; p++) begin
         write_registers(sink_setting[p], src_setting[p]);
         if (p == 0) run_directed();
         run_random(ITEMS_PER_PHASE);
         wait_drained();
      end

      if (book.failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
